/* rtl/biquad_q30_with_steady_state_prime_assert.svh */
// assertion macros for the biquad block
`ifndef BIQUAD_Q30_WITH_STEADY_STATE_PRIME_ASSERT_SVH
`define BIQUAD_Q30_WITH_STEADY_STATE_PRIME_ASSERT_SVH
`ifndef SYNTHESIS
`define BQS_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("bqs assertion failed");
`define BQS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("bqs assertion failed");
`else
`define BQS_ASSERT_SAME(lbl, ante, cons)
`define BQS_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

/* rtl/bqs_pkg.sv */
package bqs_pkg;

  localparam int FRAC_BITS = 30;
  localparam int DATA_W    = 32;
  localparam int PROD_W    = 2 * DATA_W;
  // five products of 64 bits plus rounding need 66 bits
  localparam int ACC_W     = PROD_W + 2;
  // 2^frac + a1 + a2
  localparam int DEN_W     = DATA_W + 2;
  localparam int CNT_W     = $clog2(ACC_W);
  localparam int UPC_W     = 4;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_B0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_B1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_B2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_A1 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_A2 = 3'd4;

  typedef logic [UPC_W-1:0] upc_t;

  localparam upc_t UPC_DISPATCH  = 4'd0;
  localparam upc_t UPC_FILT_FIN  = 4'd6;
  localparam upc_t UPC_PRIME     = 4'd8;
  localparam upc_t UPC_DIV_INIT  = 4'd11;
  localparam upc_t UPC_DIV_LOOP  = 4'd12;
  localparam upc_t UPC_PRIME_FIN = 4'd13;

  typedef enum logic [2:0] {
    CSEL_B0, CSEL_B1, CSEL_B2, CSEL_A1, CSEL_A2
  } csel_e;

  typedef enum logic [2:0] {
    DSEL_X, DSEL_IH1, DSEL_IH2, DSEL_OH1, DSEL_OH2
  } dsel_e;

  typedef enum logic [2:0] {
    ACC_HOLD, ACC_LD_RND, ACC_LD_PROD, ACC_ADD, ACC_SUB
  } acc_op_e;

  typedef enum logic [1:0] {
    DIV_NONE, DIV_INIT, DIV_STEP
  } div_op_e;

  typedef enum logic [1:0] {
    JMP_NONE, JMP_MODE, JMP_DEN_ZERO, JMP_DIV_LOOP
  } jmp_e;

  // one microcode word
  typedef struct packed {
    csel_e   csel;
    dsel_e   dsel;
    acc_op_e acc_op;
    div_op_e div_op;
    jmp_e    jmp;
    upc_t    target;
    logic    fin;
  } ctrl_t;

  // sequencer to datapath
  typedef struct packed {
    csel_e   csel;
    dsel_e   dsel;
    acc_op_e acc_op;
    div_op_e div_op;
    logic    load;
    logic    commit;
  } dp_cmd_t;

  // datapath to sequencer
  typedef struct packed {
    logic mode;
    logic den_zero;
    logic div_more;
  } dp_stat_t;

  // the product register lags the selects by one step, so the
  // accumulator op of each word consumes the previous word's product
  function automatic ctrl_t ucode(upc_t upc);
    ctrl_t w;
    w = '{csel: CSEL_B0, dsel: DSEL_X, acc_op: ACC_HOLD, div_op: DIV_NONE,
          jmp: JMP_NONE, target: UPC_DISPATCH, fin: 1'b0};
    case (upc)
      UPC_DISPATCH: begin
        w.acc_op = ACC_LD_RND;
        w.jmp    = JMP_MODE;
        w.target = UPC_PRIME;
      end
      4'd1: begin
        w.csel = CSEL_B1; w.dsel = DSEL_IH1; w.acc_op = ACC_ADD;
      end
      4'd2: begin
        w.csel = CSEL_B2; w.dsel = DSEL_IH2; w.acc_op = ACC_ADD;
      end
      4'd3: begin
        w.csel = CSEL_A1; w.dsel = DSEL_OH1; w.acc_op = ACC_ADD;
      end
      4'd4: begin
        w.csel = CSEL_A2; w.dsel = DSEL_OH2; w.acc_op = ACC_SUB;
      end
      4'd5: begin
        w.acc_op = ACC_SUB;
      end
      UPC_FILT_FIN: begin
        w.fin = 1'b1;
      end
      UPC_PRIME: begin
        w.csel = CSEL_B1; w.acc_op = ACC_LD_PROD;
      end
      4'd9: begin
        w.csel = CSEL_B2; w.acc_op = ACC_ADD;
      end
      4'd10: begin
        w.acc_op = ACC_ADD;
      end
      UPC_DIV_INIT: begin
        w.div_op = DIV_INIT;
        w.jmp    = JMP_DEN_ZERO;
        w.target = UPC_PRIME_FIN;
      end
      UPC_DIV_LOOP: begin
        w.div_op = DIV_STEP;
        w.jmp    = JMP_DIV_LOOP;
        w.target = UPC_DIV_LOOP;
      end
      UPC_PRIME_FIN: begin
        w.fin = 1'b1;
      end
      default: begin
        w.fin = 1'b1;
      end
    endcase
    return w;
  endfunction

endpackage

/* rtl/bqs_datapath.sv */
module bqs_datapath (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [bqs_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [bqs_pkg::DATA_W-1:0]        cfg_wdata_i,
  input  logic                              mode_i,
  input  logic signed [bqs_pkg::DATA_W-1:0] sample_i,
  input  bqs_pkg::dp_cmd_t                  cmd_i,
  output bqs_pkg::dp_stat_t                 stat_o,
  output logic signed [bqs_pkg::DATA_W-1:0] value_o,
  output logic                              clipped_o
);
  import bqs_pkg::*;

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic signed [ACC_W-1:0]  acc_t;
  typedef logic signed [DEN_W-1:0]  den_t;

  localparam acc_t ACC_RND = acc_t'(1) <<< (FRAC_BITS - 1);
  localparam den_t DEN_ONE = den_t'(1) <<< FRAC_BITS;
  localparam acc_t ACC_MAX32 = {{(ACC_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};
  localparam acc_t ACC_MIN32 = {{(ACC_W-DATA_W+1){1'b1}}, {(DATA_W-1){1'b0}}};
  localparam data_t D_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam data_t D_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  data_t b0_q, b1_q, b2_q, a1_q, a2_q;
  data_t ih1_q, ih2_q, oh1_q, oh2_q;
  data_t x_q;
  logic  mode_q;
  logic signed [PROD_W-1:0] prod_q, prod_d;
  acc_t  acc_q, acc_d;
  logic [ACC_W-1:0]   dq_q, dq_d;
  logic [DEN_W-2:0]   rem_q, rem_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               neg_q, neg_d;
  data_t              val_q, res_val;
  logic               clip_q, res_clip;

  data_t            coef, opnd;
  den_t             den, den_abs;
  logic [DEN_W-2:0] den_mag;
  logic [ACC_W-1:0] acc_mag;
  logic [DEN_W-1:0] rem_sh, rem_diff;
  logic             rem_ge;
  acc_t             shifted;
  logic [ACC_W-1:0] q_lim;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b0_q <= DEN_ONE[DATA_W-1:0];
      b1_q <= '0;
      b2_q <= '0;
      a1_q <= '0;
      a2_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_B0:  b0_q <= cfg_wdata_i;
        CFG_B1:  b1_q <= cfg_wdata_i;
        CFG_B2:  b2_q <= cfg_wdata_i;
        CFG_A1:  a1_q <= cfg_wdata_i;
        CFG_A2:  a2_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cmd_i.csel)
      CSEL_B0: coef = b0_q;
      CSEL_B1: coef = b1_q;
      CSEL_B2: coef = b2_q;
      CSEL_A1: coef = a1_q;
      CSEL_A2: coef = a2_q;
      default: coef = '0;
    endcase
    case (cmd_i.dsel)
      DSEL_X:   opnd = x_q;
      DSEL_IH1: opnd = ih1_q;
      DSEL_IH2: opnd = ih2_q;
      DSEL_OH1: opnd = oh1_q;
      DSEL_OH2: opnd = oh2_q;
      default:  opnd = '0;
    endcase
  end

  assign prod_d = coef * opnd;

  always_comb begin
    case (cmd_i.acc_op)
      ACC_LD_RND:  acc_d = ACC_RND;
      ACC_LD_PROD: acc_d = acc_t'(prod_q);
      ACC_ADD:     acc_d = acc_q + acc_t'(prod_q);
      ACC_SUB:     acc_d = acc_q - acc_t'(prod_q);
      default:     acc_d = acc_q;
    endcase
  end

  // divisor for the steady-state gain
  assign den     = DEN_ONE + den_t'(a1_q) + den_t'(a2_q);
  assign den_abs = den[DEN_W-1] ? -den : den;
  assign den_mag = den_abs[DEN_W-2:0];
  assign acc_mag = acc_q[ACC_W-1] ? ACC_W'(-acc_q) : ACC_W'(acc_q);

  // one restoring division step: shift in the next dividend bit
  assign rem_sh   = {rem_q, dq_q[ACC_W-1]};
  assign rem_ge   = rem_sh >= {1'b0, den_mag};
  assign rem_diff = rem_sh - {1'b0, den_mag};

  always_comb begin
    dq_d  = dq_q;
    rem_d = rem_q;
    cnt_d = cnt_q;
    neg_d = neg_q;
    case (cmd_i.div_op)
      DIV_INIT: begin
        dq_d  = acc_mag;
        rem_d = '0;
        cnt_d = CNT_W'(ACC_W - 1);
        neg_d = acc_q[ACC_W-1] ^ den[DEN_W-1];
      end
      DIV_STEP: begin
        dq_d  = {dq_q[ACC_W-2:0], rem_ge};
        rem_d = rem_ge ? rem_diff[DEN_W-2:0] : rem_sh[DEN_W-2:0];
        if (cnt_q != '0) begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign shifted = acc_q >>> FRAC_BITS;
  // magnitude limit is 2^31 for a negative quotient, 2^31-1 otherwise
  assign q_lim   = {{(ACC_W-DATA_W){1'b0}}, neg_q, {(DATA_W-1){~neg_q}}};

  always_comb begin
    res_clip = 1'b0;
    if (mode_q) begin
      if (den == '0) begin
        res_val  = '0;
        res_clip = 1'b1;
      end else if (dq_q > q_lim) begin
        res_val  = neg_q ? D_MIN : D_MAX;
        res_clip = 1'b1;
      end else begin
        res_val = neg_q ? data_t'(-dq_q[DATA_W-1:0]) : data_t'(dq_q[DATA_W-1:0]);
      end
    end else begin
      if (shifted > ACC_MAX32) begin
        res_val  = D_MAX;
        res_clip = 1'b1;
      end else if (shifted < ACC_MIN32) begin
        res_val  = D_MIN;
        res_clip = 1'b1;
      end else begin
        res_val = shifted[DATA_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ih1_q <= '0;
      ih2_q <= '0;
      oh1_q <= '0;
      oh2_q <= '0;
    end else if (cmd_i.commit) begin
      if (mode_q) begin
        ih1_q <= x_q;
        ih2_q <= x_q;
        oh1_q <= res_val;
        oh2_q <= res_val;
      end else begin
        ih1_q <= x_q;
        ih2_q <= ih1_q;
        oh1_q <= res_val;
        oh2_q <= oh1_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    acc_q  <= acc_d;
    dq_q   <= dq_d;
    rem_q  <= rem_d;
    cnt_q  <= cnt_d;
    neg_q  <= neg_d;
    if (cmd_i.load) begin
      x_q    <= sample_i;
      mode_q <= mode_i;
    end
    if (cmd_i.commit) begin
      val_q  <= res_val;
      clip_q <= res_clip;
    end
  end

  assign stat_o.mode     = mode_q;
  assign stat_o.den_zero = den == '0;
  assign stat_o.div_more = cnt_q != '0;
  assign value_o         = val_q;
  assign clipped_o       = clip_q;

endmodule

/* rtl/biquad_q30_with_steady_state_prime.sv */
// direct form I biquad, Q30 coefficients, with a steady-state prime
// input channel: in_valid_i / in_stall_o carry mode_i and sample_i;
//   mode 0 filters one sample, mode 1 primes the history to steady state
// output channel: out_valid_o / out_stall_i carry value_o and clipped_o,
//   one result per input transaction, held in an output register
// coefficients are written through cfg_we_i / cfg_idx_i / cfg_wdata_i
//   (b0, b1, b2, a1, a2 at index 0..4); the user must do so only while
//   the block is idle, as the block itself does not enforce this
// a microcode sequencer steps one shared 32x32 multiplier and a 66-bit
//   accumulator; a new filter transaction can be accepted in the same
//   cycle as the previous result appears
// a prime transaction runs three multiply steps and then a restoring
//   divider at one quotient bit per cycle over 66 bits; the divider is
//   skipped when the divisor is zero
// in_stall_o is high while a transaction is in work; a finished result
//   waits in its final step while the previous result is still stalled
// reset loads b0 = 1.0, the other coefficients and all history to zero
module biquad_q30_with_steady_state_prime (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [bqs_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [bqs_pkg::DATA_W-1:0]        cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              mode_i,
  input  logic signed [bqs_pkg::DATA_W-1:0] sample_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [bqs_pkg::DATA_W-1:0] value_o,
  output logic                              clipped_o
);
  import bqs_pkg::*;

  `include "biquad_q30_with_steady_state_prime_assert.svh"

  logic     busy_q, busy_d;
  upc_t     upc_q, upc_d;
  logic     out_valid_q, out_valid_d;
  ctrl_t    cw;
  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic     accept, out_free, commit, taken;

  assign cw       = ucode(upc_q);
  assign accept   = in_valid_i && !busy_q;
  assign out_free = !out_valid_q || !out_stall_i;
  assign commit   = busy_q && cw.fin && out_free;

  always_comb begin
    case (cw.jmp)
      JMP_MODE:     taken = stat.mode;
      JMP_DEN_ZERO: taken = stat.den_zero;
      JMP_DIV_LOOP: taken = stat.div_more;
      default:      taken = 1'b0;
    endcase
  end

  always_comb begin
    cmd.csel   = cw.csel;
    cmd.dsel   = cw.dsel;
    cmd.acc_op = busy_q ? cw.acc_op : ACC_HOLD;
    cmd.div_op = busy_q ? cw.div_op : DIV_NONE;
    cmd.load   = accept;
    cmd.commit = commit;
  end

  always_comb begin
    busy_d = busy_q;
    upc_d  = upc_q;
    if (!busy_q) begin
      if (accept) begin
        busy_d = 1'b1;
        upc_d  = UPC_DISPATCH;
      end
    end else if (cw.fin) begin
      // last step holds until the output register is free
      if (out_free) begin
        busy_d = 1'b0;
      end
    end else begin
      upc_d = taken ? cw.target : upc_q + 1'b1;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (commit) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      upc_q       <= UPC_DISPATCH;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      upc_q       <= upc_d;
      out_valid_q <= out_valid_d;
    end
  end

  bqs_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .mode_i      (mode_i),
    .sample_i    (sample_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .value_o     (value_o),
    .clipped_o   (clipped_o)
  );

  assign in_stall_o  = busy_q;
  assign out_valid_o = out_valid_q;

  // an accepted transaction keeps the input side stalled
  `BQS_ASSERT_NEXT(a_accept_busy, in_valid_i && !in_stall_o, in_stall_o)
  // a result only appears out of work in progress
  `BQS_ASSERT_SAME(a_result_from_work, $rose(out_valid_q), $past(busy_q))
  // the divider only runs for a prime transaction
  `BQS_ASSERT_SAME(a_div_only_prime, busy_q && (cw.div_op == DIV_STEP), stat.mode)

endmodule
